// ----- rtl/byte_ring_queue_atomic_push_pop_unit_defines.svh -----
// Assertion macros used by the byte ring queue top level.
`ifndef BYTE_RING_QUEUE_ATOMIC_PUSH_POP_UNIT_DEFINES_SVH
`define BYTE_RING_QUEUE_ATOMIC_PUSH_POP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/brq_pkg.sv -----
// Shared types and constants of the byte ring queue.
package brq_pkg;

    localparam int DEPTH_DEFAULT   = 512;
    localparam int MAX_POP_DEFAULT = 64;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int COUNT_W = 7;
    localparam int FIELD_W = 9;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam int CMD_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_PUSH        = 2'd0,
        ACT_POP_AT_MOST = 2'd1,
        ACT_POP_EXACT   = 2'd2,
        ACT_NONE        = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_PUSH_OK     = 2'd0,
        ST_PUSH_REJECT = 2'd1,
        ST_POPPED      = 2'd2,
        ST_POP_FAIL    = 2'd3
    } status_t;

    // One classified request as it waits between the front and the back end.
    typedef struct packed {
        logic               is_pop;
        logic               exact;
        logic [BYTE_W-1:0]  data;
        logic               first;
        logic               last;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

// ----- rtl/brq_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module brq_front
    import brq_pkg::*;
#(
    parameter int MAX_POP = MAX_POP_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  action_t            action,
    input  logic [BYTE_W-1:0]  push_byte,
    input  logic               msg_first,
    input  logic               msg_last,
    input  logic [LEN_W-1:0]   msg_len,
    input  logic [COUNT_W-1:0] pop_count,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output cmd_t               cmd
);

    localparam int QPW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [QPW-1:0]     Q_LAST    = QPW'(CMD_QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0]     Q_FULL    = QCW'(CMD_QUEUE_DEPTH);
    localparam logic [COUNT_W-1:0] POP_LIMIT = COUNT_W'(MAX_POP);

    cmd_t           q_mem_reg [CMD_QUEUE_DEPTH];
    logic [QPW-1:0] q_wr_reg;
    logic [QPW-1:0] q_wr_next;
    logic [QPW-1:0] q_rd_reg;
    logic [QPW-1:0] q_rd_next;
    logic [QCW-1:0] q_cnt_reg;
    logic [QCW-1:0] q_cnt_next;

    cmd_t decoded;
    logic enq;
    logic deq;

    always_comb
    begin
        decoded.is_pop = (action != ACT_PUSH);
        decoded.exact  = (action == ACT_POP_EXACT);
        decoded.data   = push_byte;
        decoded.first  = msg_first;
        decoded.last   = msg_last;
        // A zero length counts as one byte for the fit test.
        decoded.len    = (msg_len == '0) ? LEN_W'(1) : msg_len;
        decoded.count  = (pop_count > POP_LIMIT) ? POP_LIMIT : pop_count;
    end

    assign in_ready  = (q_cnt_reg != Q_FULL);
    assign cmd_valid = (q_cnt_reg != '0);
    assign cmd       = q_mem_reg[q_rd_reg];

    // Requests with the unused action code are taken and dropped here.
    assign enq = in_valid && in_ready && (action != ACT_NONE);
    assign deq = cmd_valid && cmd_ready;

    always_comb
    begin
        q_wr_next  = enq ? ((q_wr_reg == Q_LAST) ? '0 : q_wr_reg + 1'b1) : q_wr_reg;
        q_rd_next  = deq ? ((q_rd_reg == Q_LAST) ? '0 : q_rd_reg + 1'b1) : q_rd_reg;
        q_cnt_next = q_cnt_reg;
        if (enq && !deq)
        begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[q_wr_reg] <= decoded;
        end
    end

endmodule

// ----- rtl/brq_back.sv -----
// Back end: ring storage, message commit logic and the pop sequencer.
module brq_back
    import brq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output status_t            status,
    output logic [BYTE_W-1:0]  pop_byte,
    output logic               run_last,
    output logic [FIELD_W-1:0] occupied,
    output logic [FIELD_W-1:0] free_space
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam logic [AW-1:0] CAPACITY = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_POP  = 2'b10
    } back_state_t;

    logic [BYTE_W-1:0] mem [DEPTH];

    back_state_t        state_reg;
    logic [AW-1:0]      rp_reg;
    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      fill_reg;
    logic               open_reg;
    logic               rej_reg;
    logic [AW-1:0]      mbytes_reg;
    logic [COUNT_W-1:0] remain_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic [AW-1:0]      out_fill_reg;

    logic               out_free;
    logic               take;
    logic               pop_fire;
    logic [AW-1:0]      free_now;
    logic               open_eff;
    logic [AW-1:0]      bytes_eff;
    logic               rej_pre;
    logic               fits;
    logic               rej_post;
    logic               do_write;
    logic [AW-1:0]      bytes_post;
    logic [AW:0]        wr_sum;
    logic [AW-1:0]      wr_addr;
    logic [AW:0]        commit_sum;
    logic [AW-1:0]      commit_ptr;
    logic [AW-1:0]      fill_commit;
    logic               pop_fail;
    logic [COUNT_W-1:0] pop_n;
    logic [AW-1:0]      rp_inc;

    function automatic logic [FIELD_W-1:0] to_field(input logic [AW-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[FIELD_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == BK_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign pop_fire  = (state_reg == BK_POP) && out_free;
    assign free_now  = CAPACITY - fill_reg;

    // A result comes from a closing push byte, a failed pop or a popped byte;
    // a result that has not been taken yet is held.
    assign out_valid_next = pop_fire || (take && (cmd.is_pop ? pop_fail : cmd.last))
                            || (out_valid_reg && !out_ready);

    // Push evaluation: a first byte opens a fresh message and decides the fit
    // against the free space; every later byte is checked again on its own.
    always_comb
    begin
        open_eff    = cmd.first || open_reg;
        bytes_eff   = cmd.first ? '0 : mbytes_reg;
        rej_pre     = cmd.first ? (CW'(cmd.len) > CW'(free_now)) : rej_reg;
        fits        = (CW'(bytes_eff) + CW'(1)) <= CW'(free_now);
        do_write    = open_eff && !rej_pre && fits;
        rej_post    = rej_pre || !fits;
        bytes_post  = do_write ? (bytes_eff + 1'b1) : bytes_eff;
        wr_sum      = (AW + 1)'(wp_reg) + (AW + 1)'(bytes_eff);
        wr_addr     = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : AW'(wr_sum);
        commit_sum  = (AW + 1)'(wp_reg) + (AW + 1)'(bytes_post);
        commit_ptr  = (commit_sum >= DEPTH_W) ? AW'(commit_sum - DEPTH_W)
                                              : AW'(commit_sum);
        fill_commit = fill_reg + bytes_post;
    end

    always_comb
    begin
        pop_fail = (cmd.count == '0) || (fill_reg == '0)
                   || (cmd.exact && (CW'(fill_reg) < CW'(cmd.count)));
        pop_n    = (CW'(fill_reg) < CW'(cmd.count)) ? COUNT_W'(fill_reg) : cmd.count;
        rp_inc   = (rp_reg == CAPACITY) ? '0 : rp_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            open_reg       <= 1'b0;
            rej_reg        <= 1'b0;
            mbytes_reg     <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_PUSH_OK;
            out_last_reg   <= 1'b0;
            out_fill_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                BK_IDLE:
                begin
                    if (take && !cmd.is_pop)
                    begin
                        if (!open_eff)
                        begin
                            // A stray byte is dropped; its last mark still reports.
                            if (cmd.last)
                            begin
                                out_status_reg <= ST_PUSH_REJECT;
                                out_last_reg   <= 1'b1;
                                out_fill_reg   <= fill_reg;
                            end
                        end
                        else if (cmd.last)
                        begin
                            open_reg      <= 1'b0;
                            rej_reg       <= 1'b0;
                            mbytes_reg    <= '0;
                            out_last_reg  <= 1'b1;
                            if (rej_post)
                            begin
                                out_status_reg <= ST_PUSH_REJECT;
                                out_fill_reg   <= fill_reg;
                            end
                            else
                            begin
                                wp_reg         <= commit_ptr;
                                fill_reg       <= fill_commit;
                                out_status_reg <= ST_PUSH_OK;
                                out_fill_reg   <= fill_commit;
                            end
                        end
                        else
                        begin
                            open_reg   <= 1'b1;
                            rej_reg    <= rej_post;
                            mbytes_reg <= bytes_post;
                        end
                    end
                    else if (take)
                    begin
                        if (pop_fail)
                        begin
                            out_status_reg <= ST_POP_FAIL;
                            out_last_reg   <= 1'b1;
                            out_fill_reg   <= fill_reg;
                        end
                        else
                        begin
                            remain_reg <= pop_n;
                            state_reg  <= BK_POP;
                        end
                    end
                end
                BK_POP:
                begin
                    if (pop_fire)
                    begin
                        rp_reg         <= rp_inc;
                        fill_reg       <= fill_reg - 1'b1;
                        remain_reg     <= remain_reg - 1'b1;
                        out_status_reg <= ST_POPPED;
                        out_last_reg   <= (remain_reg == COUNT_W'(1));
                        out_fill_reg   <= fill_reg - 1'b1;
                        if (remain_reg == COUNT_W'(1))
                        begin
                            state_reg <= BK_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

    // Ring storage; the read data register doubles as the output byte.
    always_ff @(posedge clk)
    begin
        if (take && !cmd.is_pop && do_write)
        begin
            mem[wr_addr] <= cmd.data;
        end
        if (pop_fire)
        begin
            out_byte_reg <= mem[rp_reg];
        end
        else if (take)
        begin
            out_byte_reg <= '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign pop_byte   = out_byte_reg;
    assign run_last   = out_last_reg;
    assign occupied   = to_field(out_fill_reg);
    assign free_space = to_field(CAPACITY - out_fill_reg);

endmodule

// ----- rtl/byte_ring_queue_atomic_push_pop_unit.sv -----
// Circular byte queue with whole-message push and counted pops.
//
// The queue keeps one slot free, so it holds at most DEPTH-1 bytes. A push
// message arrives one byte per request and is committed, with one status
// result, at its last byte; it is dropped whole if it does not fit. Each push
// byte is handled by the back end in its idle state. A pop that finds data first
// moves the back end into its pop state and then emits one byte per cycle while
// the output is not stalled; a failed pop returns just a status result.
// The single read port of the ring storage and the back-end sequencer set this
// pace. A two-entry request queue lets the input side keep accepting while the
// back end is busy or the output is stalled. The storage has no clearing pass
// after reset: only bytes written by a committed push are ever read.
`include "byte_ring_queue_atomic_push_pop_unit_defines.svh"

module byte_ring_queue_atomic_push_pop_unit
    import brq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int MAX_POP = MAX_POP_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // push_byte[7:0], msg_first[8], msg_len[17:9], pop_count[24:18], zeros above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pop_byte_out[7:0], occupied[16:8], free_space[25:17], zeros above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam logic [FIELD_W-1:0] FREE_TOTAL = FIELD_W'((DEPTH - 1) % 512);

    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;
    status_t            status;
    logic [BYTE_W-1:0]  pop_byte;
    logic [FIELD_W-1:0] occupied;
    logic [FIELD_W-1:0] free_space;

    brq_front #(
        .MAX_POP (MAX_POP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (action_t'(s_axis_tuser)),
        .push_byte (s_axis_tdata[7:0]),
        .msg_first (s_axis_tdata[8]),
        .msg_last  (s_axis_tlast),
        .msg_len   (s_axis_tdata[17:9]),
        .pop_count (s_axis_tdata[24:18]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    brq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .pop_byte   (pop_byte),
        .run_last   (m_axis_tlast),
        .occupied   (occupied),
        .free_space (free_space)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - 2 * FIELD_W){1'b0}},
                           free_space, occupied, pop_byte};

    `BRQ_ASSERT_SAME(a_non_pop_is_last, m_axis_tvalid && m_axis_tuser != ST_POPPED, m_axis_tlast, "status result without last mark")
    `BRQ_ASSERT_SAME(a_non_pop_zero_byte, m_axis_tvalid && m_axis_tuser != ST_POPPED, m_axis_tdata[7:0] == 8'h00, "status result with nonzero byte")
    `BRQ_ASSERT_SAME(a_space_sum, m_axis_tvalid, FIELD_W'(m_axis_tdata[16:8] + m_axis_tdata[25:17]) == FREE_TOTAL, "occupied and free space disagree")
    `BRQ_ASSERT_NEXT(a_cmd_held, cmd_valid && !cmd_ready, cmd_valid, "queued request vanished while stalled")

endmodule

// ----- tb/tb_byte_ring_queue_atomic_push_pop_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the byte ring queue: streamed push and pop requests against a local model.
module tb_byte_ring_queue_atomic_push_pop_unit;
    import brq_pkg::*;

    localparam int RING_SLOTS     = DEPTH_DEFAULT;
    localparam int POP_LIMIT      = MAX_POP_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        status_t     status;
        logic [7:0]  data;
        logic        last;
        logic [8:0]  occupied;
        logic [8:0]  free_space;
    } ring_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    byte_ring_queue_atomic_push_pop_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Local copy of the queue state, advanced on every accepted push or pop request.
    logic [7:0]   ring_bytes [RING_SLOTS];
    int unsigned  ring_rd = 0;
    int unsigned  ring_wr = 0;
    int unsigned  ring_fill = 0;
    bit           msg_active = 1'b0;
    bit           msg_dropped = 1'b0;
    int unsigned  msg_staged = 0;

    ring_result_t pending_results[$];
    ring_result_t seen_result;
    ring_result_t want_result;

    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_cycles = 0;
    int  hold_len = 0;
    bit  hold_tgl = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned ring_room();
        return RING_SLOTS - 1 - ring_fill;
    endfunction

    function automatic void queue_result(status_t st, logic [7:0] data, logic last);
        ring_result_t r;
        r.status     = st;
        r.data       = data;
        r.last       = last;
        r.occupied   = ring_fill[8:0];
        r.free_space = 9'(ring_room());
        pending_results.push_back(r);
    endfunction

    function automatic void predict_push(logic [7:0] data, logic first, logic last,
                                         logic [8:0] len);
        int unsigned need;
        need = len;
        if (first)
        begin
            if (need == 0)
                need = 1;
            msg_active  = 1'b1;
            msg_staged  = 0;
            msg_dropped = need > ring_room();
        end
        if (!msg_active)
        begin
            if (last)
                queue_result(ST_PUSH_REJECT, 8'h00, 1'b1);
            return;
        end
        // Bytes are staged ahead of the write pointer until the message closes.
        if (!msg_dropped)
        begin
            if (msg_staged + 1 > ring_room())
                msg_dropped = 1'b1;
            else
            begin
                ring_bytes[(ring_wr + msg_staged) % RING_SLOTS] = data;
                msg_staged++;
            end
        end
        if (!last)
            return;
        msg_active = 1'b0;
        if (msg_dropped)
        begin
            msg_dropped = 1'b0;
            msg_staged  = 0;
            queue_result(ST_PUSH_REJECT, 8'h00, 1'b1);
        end
        else
        begin
            ring_wr    = (ring_wr + msg_staged) % RING_SLOTS;
            ring_fill += msg_staged;
            msg_staged = 0;
            queue_result(ST_PUSH_OK, 8'h00, 1'b1);
        end
    endfunction

    function automatic void predict_pop(logic [6:0] count, bit exact);
        int unsigned want;
        int unsigned take;
        want = (count > POP_LIMIT) ? POP_LIMIT : count;
        if (want == 0 || ring_fill == 0 || (exact && ring_fill < want))
        begin
            queue_result(ST_POP_FAIL, 8'h00, 1'b1);
            return;
        end
        take = (ring_fill < want) ? ring_fill : want;
        for (int unsigned i = 0; i < take; i++)
        begin
            logic [7:0] b;
            b       = ring_bytes[ring_rd];
            ring_rd = (ring_rd + 1) % RING_SLOTS;
            ring_fill--;
            queue_result(ST_POPPED, b, i + 1 == take);
        end
    endfunction

    function automatic void note_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Sends one request; the valid stays high into the next call unless that call idles.
    task automatic send_item(action_t act, logic [7:0] data, logic first, logic last,
                             logic [8:0] len, logic [6:0] count);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, count, len, first, data};
        s_axis_tuser  <= act;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (act)
            ACT_PUSH:        predict_push(data, first, last, len);
            ACT_POP_AT_MOST: predict_pop(count, 1'b0);
            ACT_POP_EXACT:   predict_pop(count, 1'b1);
            default:         ;
        endcase
    endtask

    task automatic send_pop(action_t act, logic [6:0] count);
        send_item(act, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 9'($urandom_range(511)), count);
    endtask

    task automatic push_message(int unsigned declared, int unsigned actual);
        for (int unsigned i = 0; i < actual; i++)
            send_item(ACT_PUSH, 8'($urandom_range(255)), i == 0, i + 1 == actual,
                      declared[8:0], 7'($urandom_range(127)));
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_pop(ACT_POP_AT_MOST, 7'd1);
        send_pop(ACT_POP_EXACT, 7'd5);
        send_item(ACT_PUSH, 8'h00, 1'b1, 1'b0, 9'd3, 7'd0);
        send_item(ACT_PUSH, 8'hFF, 1'b0, 1'b0, 9'd0, 7'h7F);
        send_item(ACT_PUSH, 8'hA5, 1'b0, 1'b1, 9'h1FF, 7'd0);
        send_pop(ACT_POP_AT_MOST, 7'd0);
        send_pop(ACT_POP_EXACT, 7'd4);
        send_pop(ACT_POP_AT_MOST, 7'd2);
        // Bytes outside any message: one with the last mark, one without.
        send_item(ACT_PUSH, 8'h3C, 1'b0, 1'b1, 9'd1, 7'd1);
        send_item(ACT_PUSH, 8'hC3, 1'b0, 1'b0, 9'd1, 7'd1);
        // A declared length of zero counts as one byte.
        send_item(ACT_PUSH, 8'h11, 1'b1, 1'b1, 9'd0, 7'd0);
        // A new first byte silently drops the message that was still open.
        send_item(ACT_PUSH, 8'h22, 1'b1, 1'b0, 9'd4, 7'd0);
        send_item(ACT_PUSH, 8'h33, 1'b0, 1'b0, 9'd4, 7'd0);
        push_message(2, 2);
        // A pop while a message is open sees only committed bytes.
        send_item(ACT_PUSH, 8'h44, 1'b1, 1'b0, 9'd2, 7'd0);
        send_pop(ACT_POP_AT_MOST, 7'd64);
        send_item(ACT_PUSH, 8'h55, 1'b0, 1'b1, 9'd2, 7'd0);
        send_item(ACT_PUSH, 8'h66, 1'b1, 1'b1, 9'd511, 7'd0);
        send_item(ACT_NONE, 8'hFF, 1'b1, 1'b1, 9'h1FF, 7'h7F);
        send_pop(ACT_POP_AT_MOST, 7'd127);
        // More bytes arrive than the declared length says.
        push_message(2, 4);
        send_pop(ACT_POP_EXACT, 7'd3);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(int items, int s_idle, int r_idle);
        int unsigned n;
        int unsigned declared;
        int          sent;
        int          r;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                n        = ($urandom_range(9) == 0) ? $urandom_range(21, 80)
                                                    : $urandom_range(1, 12);
                declared = ($urandom_range(9) == 0) ? $urandom_range(511) : n;
                push_message(declared, n);
                sent += n;
            end
            else if (r < 80)
            begin
                send_pop($urandom_range(1) ? ACT_POP_AT_MOST : ACT_POP_EXACT,
                         7'(($urandom_range(7) == 0) ? $urandom_range(127)
                                                     : $urandom_range(1, 16)));
                sent++;
            end
            else if (r < 85)
            begin
                send_item(ACT_PUSH, 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          9'($urandom_range(511)), 7'($urandom_range(127)));
                sent++;
            end
            else if (r < 90)
            begin
                send_item(ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 9'($urandom_range(511)),
                          7'($urandom_range(127)));
                sent++;
            end
            else
            begin
                // A message that never closes; the next first byte drops it.
                n = $urandom_range(1, 3);
                for (int unsigned j = 0; j < n; j++)
                    send_item(ACT_PUSH, 8'($urandom_range(255)), j == 0, 1'b0,
                              9'($urandom_range(1, 20)), 7'($urandom_range(127)));
                sent += n;
            end
        end
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_message(48, 48);
        hold_len <= 200;
        hold_tgl <= ~hold_tgl;
        for (int i = 0; i < 6; i++)
            send_pop(ACT_POP_AT_MOST, 7'd8);
        wait_for_drain();
    endtask

    task automatic test_fill_to_capacity();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (ring_room() >= 60)
            push_message(60, 60);
        // The declared length fits, but the bytes that arrive overflow the room.
        push_message(1, ring_room() + 2);
        if (ring_room() > 0)
            push_message(ring_room(), ring_room());
        push_message(1, 1);
        push_message(0, 1);
        while (ring_fill > 0)
            send_pop($urandom_range(1) ? ACT_POP_AT_MOST : ACT_POP_EXACT, 7'd64);
        send_pop(ACT_POP_AT_MOST, 7'd64);
        wait_for_drain();
    endtask

    // Result checker and receiver-side ready; a hold-off stretch is counted here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.status     = status_t'(m_axis_tuser);
                seen_result.data       = m_axis_tdata[7:0];
                seen_result.last       = m_axis_tlast;
                seen_result.occupied   = m_axis_tdata[16:8];
                seen_result.free_space = m_axis_tdata[25:17];
                if (pending_results.size() == 0)
                    note_error($sformatf("unexpected result: status %0d byte %02h last %0d",
                                         seen_result.status, seen_result.data,
                                         seen_result.last));
                else
                begin
                    want_result = pending_results.pop_front();
                    if (seen_result.status !== want_result.status ||
                        seen_result.data !== want_result.data ||
                        seen_result.last !== want_result.last ||
                        seen_result.occupied !== want_result.occupied ||
                        seen_result.free_space !== want_result.free_space)
                        note_error($sformatf({"result mismatch: expected status %0d ",
                                              "byte %02h last %0d occupied %0d free %0d, ",
                                              "got status %0d byte %02h last %0d ",
                                              "occupied %0d free %0d"},
                                             want_result.status, want_result.data,
                                             want_result.last, want_result.occupied,
                                             want_result.free_space, seen_result.status,
                                             seen_result.data, seen_result.last,
                                             seen_result.occupied,
                                             seen_result.free_space));
                end
            end
            if (hold_tgl != hold_seen)
            begin
                hold_seen     <= hold_tgl;
                hold_left     <= hold_len;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(40, 20, 77);
        test_random_traffic(40, 77, 20);
        test_random_traffic(40, 0, 0);
        test_output_backpressure();
        test_fill_to_capacity();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
